FILE: rtl/u8dec_pkg.sv
`timescale 1ns / 1ps
// Package: widths, masks and lead-byte helpers for the UTF-8 decoder.
package u8dec_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int LEN_W  = 3;
  localparam int LEFT_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [LEN_W-1:0]  seq_len_t;
  typedef logic [LEFT_W-1:0] left_t;

  // sequence lengths claimed by a lead byte
  localparam seq_len_t LEN_1 = 3'd1;
  localparam seq_len_t LEN_2 = 3'd2;
  localparam seq_len_t LEN_3 = 3'd3;
  localparam seq_len_t LEN_4 = 3'd4;

  localparam byte_t TOP1_MASK  = 8'b1000_0000;
  localparam byte_t TOP3_MASK  = 8'b1110_0000;
  localparam byte_t LEAD2_CODE = 8'b1100_0000;
  localparam byte_t TOP4_MASK  = 8'b1111_0000;
  localparam byte_t LEAD3_CODE = 8'b1110_0000;
  localparam byte_t CONT_MASK  = 8'b0011_1111;
  localparam byte_t LEAD4_MASK = 8'b0000_0111;
  localparam byte_t LEAD3_MASK = 8'b0000_1111;
  localparam byte_t LEAD2_MASK = 8'b0001_1111;
  localparam byte_t LEAD1_MASK = 8'b0111_1111;

  // anything not a 1, 2 or 3 byte lead counts as a 4 byte lead
  function automatic seq_len_t lead_length(byte_t b);
    seq_len_t len;
    if ((b & TOP1_MASK) == '0) begin
      len = LEN_1;
    end else if ((b & TOP3_MASK) == LEAD2_CODE) begin
      len = LEN_2;
    end else if ((b & TOP4_MASK) == LEAD3_CODE) begin
      len = LEN_3;
    end else begin
      len = LEN_4;
    end
    return len;
  endfunction

  function automatic byte_t lead_bits(byte_t b, seq_len_t len);
    byte_t v;
    unique case (len)
      LEN_1:   v = b & LEAD1_MASK;
      LEN_2:   v = b & LEAD2_MASK;
      LEN_3:   v = b & LEAD3_MASK;
      default: v = b & LEAD4_MASK;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/u8dec_in_if.sv
`timescale 1ns / 1ps
// Interface: byte channel into the UTF-8 decoder.
interface u8dec_in_if
  import u8dec_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

FILE: rtl/u8dec_out_if.sv
`timescale 1ns / 1ps
// Interface: code point channel out of the UTF-8 decoder.
interface u8dec_out_if
  import u8dec_pkg::*;
;
  logic     valid;
  logic     ready;
  cp_t      code_point;
  seq_len_t sequence_length;
  logic     truncated;
  logic     stream_done;

  modport source (output valid, output code_point, output sequence_length,
                  output truncated, output stream_done, input ready);
  modport sink   (input valid, input code_point, input sequence_length,
                  input truncated, input stream_done, output ready);
endinterface

FILE: rtl/utf8_to_utf32_decoder_unit.sv
`timescale 1ns / 1ps
// Top level: UTF-8 byte stream to UTF-32 code point decoder.
// Output: a result is registered and appears on out_ch in the cycle after the byte that finishes it.
// Throughput: one byte per cycle while no held word is stalled; the single output register accepts a new
//   byte in the same cycle its held word is taken.
// Reset (rst, synchronous, active high): empties the output register and
//   returns the decoder to "expecting a lead byte". No clearing pass.
module utf8_to_utf32_decoder_unit
  import u8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  u8dec_in_if.sink    in_ch,
  u8dec_out_if.source out_ch
);

  // Decode state: continuation bytes still owed, bits so far, claimed length.
  left_t    bytes_left, bytes_left_next;
  cp_t      partial_value, partial_value_next;
  seq_len_t current_length, current_length_next;

  // Output register.
  logic     out_valid;
  cp_t      out_code_point;
  seq_len_t out_sequence_length;
  logic     out_truncated;
  logic     out_stream_done;

  logic     in_fire;
  logic     emit;
  logic     emit_trunc;
  cp_t      emit_cp;
  seq_len_t lead_len;

  // The output register frees up when it is empty or being drained this cycle.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign lead_len = lead_length(in_ch.data_byte);

  // Classify the byte and fold it into the partial code point.
  always_comb begin
    if (bytes_left == '0) begin
      current_length_next = lead_len;
      partial_value_next  = cp_t'(lead_bits(in_ch.data_byte, lead_len));
      bytes_left_next     = left_t'(lead_len - LEN_1);
    end else begin
      current_length_next = current_length;
      partial_value_next  = {partial_value[CP_W-7:0],
                             in_ch.data_byte[5:0] & CONT_MASK[5:0]};
      bytes_left_next     = bytes_left - left_t'(1);
    end
  end

  // A word goes out when the sequence completes or the stream ends early.
  // An early end pads the missing 6-bit groups with zeros.
  always_comb begin
    emit_trunc = (bytes_left_next != '0);
    emit       = !emit_trunc || in_ch.end_of_stream;
    case (bytes_left_next)
      2'd1:    emit_cp = {partial_value_next[CP_W-7:0], 6'd0};
      2'd2:    emit_cp = {partial_value_next[CP_W-13:0], 12'd0};
      2'd3:    emit_cp = {partial_value_next[CP_W-19:0], 18'd0};
      default: emit_cp = partial_value_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left     <= '0;
      partial_value  <= '0;
      current_length <= LEN_1;
    end else if (in_fire) begin
      if (in_ch.end_of_stream) begin
        // last byte of the stream: next byte starts a fresh stream
        bytes_left     <= '0;
        partial_value  <= '0;
        current_length <= LEN_1;
      end else begin
        bytes_left     <= bytes_left_next;
        partial_value  <= partial_value_next;
        current_length <= current_length_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_code_point      <= emit_cp;
      out_sequence_length <= current_length_next;
      out_truncated       <= emit_trunc;
      out_stream_done     <= in_ch.end_of_stream;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.code_point      = out_code_point;
  assign out_ch.sequence_length = out_sequence_length;
  assign out_ch.truncated       = out_truncated;
  assign out_ch.stream_done     = out_stream_done;

  // Owed continuation bytes always fewer than the claimed length.
  a_left_below_len: assert property (@(posedge clk) disable iff (rst)
    (bytes_left != '0) |-> (current_length > {1'b0, bytes_left}))
    else $error("bytes_left not below current_length");

  // The final byte always yields a word and leaves the decoder idle.
  a_eos_flushes: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.end_of_stream) |=>
      (out_valid && out_stream_done && bytes_left == '0))
    else $error("end of stream did not flush");

  // A short sequence only shows up at the end of a stream.
  a_trunc_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_truncated) |-> out_stream_done)
    else $error("truncated word without stream_done");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_sequence_length == LEN_1 || out_sequence_length == LEN_2 ||
                   out_sequence_length == LEN_3 || out_sequence_length == LEN_4))
    else $error("sequence_length out of range");

  // A held word that is not taken blocks new bytes.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("byte accepted over a stalled word");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: random and directed byte streams into the UTF-8 decoder, checked word by word.
module tb_top;
  import u8dec_pkg::*;

  // one byte word on the input channel
  typedef struct packed {
    byte_t data_byte;
    logic  end_of_stream;
  } byte_word_t;

  // one code point word on the output channel
  typedef struct packed {
    cp_t      code_point;
    seq_len_t sequence_length;
    logic     truncated;
    logic     stream_done;
  } cp_word_t;

  localparam int RAND_BYTES   = 1900;
  localparam int STALL_LIMIT  = 1000;  // cycles with no word moving on either side
  localparam int TAIL_CYCLES  = 4;     // result is registered, so this tail catches any late word
  localparam int QUIET_START  = 1000;  // cycle window with no idling on either side
  localparam int QUIET_STOP   = 1700;
  localparam int IDLE_PERCENT = 11;

  logic clk;
  logic rst;

  u8dec_in_if  byte_ch ();
  u8dec_out_if cp_ch ();

  utf8_to_utf32_decoder_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (byte_ch),
    .out_ch (cp_ch)
  );

  // stream bytes waiting to be driven, and code points waiting to be seen
  byte_word_t pending_bytes[$];
  cp_word_t   expected_cps[$];

  // decoder state mirror
  left_t    cont_left     = '0;
  cp_t      gathered_bits = '0;
  seq_len_t seq_len       = LEN_1;

  int errors = 0;
  int cycle_cnt;
  int stall_cnt;

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Reset held high at start, then released; driver and monitor keep their channel signals idle
  // while it is high.
  initial begin
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Idle decision shared by both sides; none inside the quiet window.
  // ---------------------------------------------------------------------------
  function automatic logic idle_now();
    if (cycle_cnt >= QUIET_START && cycle_cnt < QUIET_STOP) begin
      return 1'b0;
    end
    return ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  // ---------------------------------------------------------------------------
  // Code point predictor: consumes one accepted byte, may queue one word.
  // ---------------------------------------------------------------------------
  function automatic void decode_byte(byte_word_t w);
    cp_word_t cp;
    byte_t    b;
    b = w.data_byte;
    if (cont_left == '0) begin
      // lead byte picks the length; anything not 0x, 110x, 1110x is a 4 byte lead
      if ((b & TOP1_MASK) == '0) begin
        seq_len       = LEN_1;
        gathered_bits = cp_t'(b & LEAD1_MASK);
      end else if ((b & TOP3_MASK) == LEAD2_CODE) begin
        seq_len       = LEN_2;
        gathered_bits = cp_t'(b & LEAD2_MASK);
      end else if ((b & TOP4_MASK) == LEAD3_CODE) begin
        seq_len       = LEN_3;
        gathered_bits = cp_t'(b & LEAD3_MASK);
      end else begin
        seq_len       = LEN_4;
        gathered_bits = cp_t'(b & LEAD4_MASK);
      end
      cont_left = left_t'(seq_len - LEN_1);
    end else begin
      // continuation: top bits ignored, low six appended
      gathered_bits = {gathered_bits[CP_W-7:0], b[5:0]};
      cont_left     = cont_left - left_t'(1);
    end

    if (cont_left == '0) begin
      cp.code_point      = gathered_bits;
      cp.sequence_length = seq_len;
      cp.truncated       = 1'b0;
      cp.stream_done     = w.end_of_stream;
      expected_cps.push_back(cp);
    end else if (w.end_of_stream) begin
      // stream cut short: missing low bits read as zero
      cp.code_point      = gathered_bits << (6 * cont_left);
      cp.sequence_length = seq_len;
      cp.truncated       = 1'b1;
      cp.stream_done     = 1'b1;
      expected_cps.push_back(cp);
    end

    if (w.end_of_stream) begin
      cont_left     = '0;
      gathered_bits = '0;
      seq_len       = LEN_1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_byte(byte_t b, logic eos);
    byte_word_t w;
    w.data_byte     = b;
    w.end_of_stream = eos;
    pending_bytes.push_back(w);
  endtask

  // One sequence of the given length with random payload. A few leads are
  // stray continuations or 11111xxx, a few continuations are garbage, and
  // now and then the stream ends somewhere inside it.
  task automatic push_sequence(int len);
    byte_t b;
    int    eos_at;
    eos_at = ($urandom_range(99) < 4) ? $urandom_range(len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        case (len)
          1: b = {1'b0, 7'($urandom)};
          2: b = {3'b110, 5'($urandom)};
          3: b = {4'b1110, 4'($urandom)};
          default: begin
            case ($urandom_range(3))
              0:       b = {2'b10, 6'($urandom)};
              1:       b = {5'b11111, 3'($urandom)};
              default: b = {5'b11110, 3'($urandom)};
            endcase
          end
        endcase
      end else if ($urandom_range(99) < 5) begin
        b = 8'($urandom);
      end else begin
        b = {2'b10, 6'($urandom)};
      end
      push_byte(b, (i == eos_at));
      if (i == eos_at) begin
        break;
      end
    end
  endtask

  initial begin
    // directed: extremes of one byte, each length, odd leads, bad and
    // missing continuations, end of stream on a lead and on a full sequence
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hC2, 1'b0); push_byte(8'hA9, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0); push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC3, 1'b0); push_byte(8'h41, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
    push_byte(8'hF7, 1'b1);
    push_byte(8'hDF, 1'b0); push_byte(8'hBF, 1'b1);

    // random: mostly sequences, some loose bytes
    while (pending_bytes.size() < RAND_BYTES + 26) begin
      if ($urandom_range(99) < 15) begin
        push_byte(8'($urandom), ($urandom_range(99) < 5));
      end else begin
        push_sequence($urandom_range(1, 4));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: predicts on each accepted byte, then loads the next or idles.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    byte_word_t nxt;
    if (rst) begin
      byte_ch.valid         <= 1'b0;
      byte_ch.data_byte     <= '0;
      byte_ch.end_of_stream <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_word_t'{byte_ch.data_byte, byte_ch.end_of_stream});
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (pending_bytes.size() > 0 && !idle_now()) begin
          nxt = pending_bytes.pop_front();
          byte_ch.valid         <= 1'b1;
          byte_ch.data_byte     <= nxt.data_byte;
          byte_ch.end_of_stream <= nxt.end_of_stream;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each taken code point against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : cp_monitor
    cp_word_t want;
    if (rst) begin
      cp_ch.ready <= 1'b0;
    end else begin
      if (cp_ch.valid && cp_ch.ready) begin
        if (expected_cps.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual cp 0x%0h len %0d trunc %0b done %0b",
                   $time, cp_ch.code_point, cp_ch.sequence_length, cp_ch.truncated,
                   cp_ch.stream_done);
          errors++;
        end else begin
          want = expected_cps.pop_front();
          report_field("code_point", want.code_point, cp_ch.code_point);
          report_field("sequence_length", want.sequence_length, cp_ch.sequence_length);
          report_field("truncated", want.truncated, cp_ch.truncated);
          report_field("stream_done", want.stream_done, cp_ch.stream_done);
        end
      end
      cp_ch.ready <= !idle_now();
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if no word moves on either channel for too long.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cycle_cnt <= 0;
      stall_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // End of run: all bytes taken, all code points seen, then a short tail
  // to catch any word the decoder should not have produced.
  // ---------------------------------------------------------------------------
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    while (pending_bytes.size() > 0 || byte_ch.valid || expected_cps.size() > 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && expected_cps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
